@@ hw/rtl/lphi_pkg.sv @@
// ----------------------------------------------------------------------------
// lphi_pkg: shared types for the linear probe hash index
// Request, result, command and status structs, slot marks, modes, status codes, controller states.
// ----------------------------------------------------------------------------
package lphi_pkg;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] key;
		logic [47:0] new_offset;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [47:0] found_offset;
		logic [1:0]  status;
	} rsp_t;

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;
	localparam logic [1:0] MODE_SPARE  = 2'd3;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_USED  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH, S_HOME, S_READ, S_WAIT, S_CHECK, S_PLACE, S_OUT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic hash_step;
		logic set_home;
		logic advance;
		logic note_tomb;
		logic wr_match;
		logic wr_place;
		logic set_result;
		logic [1:0] res_kind;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hash_done;
		logic home_done;
		logic [1:0] mark;
		logic key_eq;
		logic have_tomb;
		logic probe_last;
		logic [1:0] mode;
	} sts_t;

	localparam logic [1:0] RK_MATCH = 2'd0;
	localparam logic [1:0] RK_MISS  = 2'd1;
	localparam logic [1:0] RK_PLACE = 2'd2;
	localparam logic [1:0] RK_FULL  = 2'd3;

endpackage

@@ hw/rtl/lphi_ram.sv @@
// ----------------------------------------------------------------------------
// lphi_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lphi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ hw/rtl/lphi_ctrl.sv @@
// ----------------------------------------------------------------------------
// lphi_ctrl: sequencer for the hash index
// Clears marks after reset, then steps hash, home reduction, probe and write.
// ----------------------------------------------------------------------------
module lphi_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  lphi_pkg::sts_t  sts,
	output lphi_pkg::cmd_t  cmd
);
	import lphi_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_done) state_d = S_HOME;
			end
			S_HOME: begin
				cmd.set_home = 1'b1;
				if (sts.home_done) state_d = S_READ;
			end
			S_READ: state_d = S_WAIT;
			S_WAIT: state_d = S_CHECK;
			S_CHECK: begin
				if (sts.mark == MARK_EMPTY) begin
					state_d = S_PLACE;
				end else if (sts.mark == MARK_USED && sts.key_eq) begin
					cmd.wr_match   = 1'b1;
					cmd.set_result = 1'b1;
					cmd.res_kind   = RK_MATCH;
					state_d        = S_OUT;
				end else begin
					cmd.note_tomb = (sts.mark == MARK_TOMB) && !sts.have_tomb;
					if (sts.probe_last) begin
						state_d = S_PLACE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_READ;
					end
				end
			end
			S_PLACE: begin
				cmd.set_result = 1'b1;
				if (sts.mode != MODE_INSERT) begin
					cmd.res_kind = RK_MISS;
				end else if (sts.have_tomb || sts.mark == MARK_EMPTY) begin
					cmd.wr_place = 1'b1;
					cmd.res_kind = RK_PLACE;
				end else begin
					cmd.res_kind = RK_FULL;
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

@@ hw/rtl/lphi_dp.sv @@
// ----------------------------------------------------------------------------
// lphi_dp: hash index datapath
// FNV-1a one byte a cycle, home slot by reciprocal multiply and one correction
// (power-of-two sizes mask at once), probe pointer and slot memories.
// ----------------------------------------------------------------------------
module lphi_dp #(
	parameter int SLOTS       = 1024,
	parameter int KEY_BYTES   = 8,
	parameter int OFFSET_BITS = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lphi_pkg::req_t req,
	output lphi_pkg::rsp_t rsp,
	input  lphi_pkg::cmd_t cmd,
	output lphi_pkg::sts_t sts
);
	import lphi_pkg::*;

	localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BW  = 4;
	localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
	localparam int OB  = (OFFSET_BITS > 48) ? 48 : OFFSET_BITS;
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SLOTS));

	logic [1:0]    mode_q;
	logic [63:0]   key_q;
	logic [47:0]   off_q;
	logic [31:0]   hash_q;
	logic [BW-1:0] bidx_q;
	logic          hdone_q;
	logic [32:0]   rem_q;
	logic [31:0]   quo_q;
	logic [1:0]    hph_q;
	logic [AW-1:0] idx_q, tomb_idx_q, clr_q;
	logic          have_tomb_q;
	logic [AW:0]   cnt_q;
	rsp_t          rsp_q;
	rsp_t          rsp_nx;

	logic [63:0] nkey;
	logic [47:0] noff;
	logic [7:0]  cur_byte;
	logic        home_ok;

	logic          mark_we, key_we, off_we;
	logic [AW-1:0] mark_a, kv_a;
	logic [1:0]    mark_wd, mark_rd;
	logic [63:0]   key_rd;
	logic [47:0]   off_rd;

	always_comb begin
		logic stop;
		nkey = '0;
		stop = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (req.key[8*i +: 8] == 8'd0) stop = 1'b1;
			if (!stop) nkey[8*i +: 8] = req.key[8*i +: 8];
		end
		noff = '0;
		noff[OB-1:0] = req.new_offset[OB-1:0];
	end

	assign cur_byte = key_q[{bidx_q[2:0], 3'b000} +: 8];
	assign home_ok  = POW2 || (hph_q == 2'd2 && rem_q < 33'(SLOTS));

	always_comb begin
		rsp_nx = '0;
		case (cmd.res_kind)
			RK_MATCH: begin
				rsp_nx.hit    = 1'b1;
				rsp_nx.status = ST_DONE;
				if (mode_q != MODE_INSERT && mode_q != MODE_DELETE)
					rsp_nx.found_offset = off_rd;
			end
			RK_MISS:  rsp_nx.status = ST_ABSENT;
			RK_PLACE: begin
				rsp_nx.hit    = 1'b1;
				rsp_nx.status = ST_DONE;
			end
			default:  rsp_nx.status = ST_FULL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q      <= req.mode;
			key_q       <= nkey;
			off_q       <= noff;
			hash_q      <= FNV_BASIS;
			bidx_q      <= '0;
			hdone_q     <= 1'b0;
			hph_q       <= '0;
			have_tomb_q <= 1'b0;
		end
		if (cmd.hash_step) begin
			if (bidx_q == BW'(KEY_BYTES) || cur_byte == 8'd0) begin
				hdone_q <= 1'b1;
				rem_q   <= {1'b0, hash_q};
			end else begin
				hash_q <= (hash_q ^ {24'd0, cur_byte}) * FNV_PRIME;
				bidx_q <= bidx_q + 1'b1;
			end
		end
		if (cmd.set_home) begin
			if (home_ok) begin
				idx_q <= rem_q[AW-1:0];
				cnt_q <= '0;
			end else begin
				case (hph_q)
					2'd0: begin
						quo_q <= 32'((64'(rem_q[31:0]) * 64'(RECIP)) >> 32);
						hph_q <= 2'd1;
					end
					2'd1: begin
						rem_q <= rem_q - 33'(64'(quo_q) * 64'(SLOTS));
						hph_q <= 2'd2;
					end
					default: rem_q <= rem_q - 33'(SLOTS);
				endcase
			end
		end
		if (cmd.note_tomb) begin
			have_tomb_q <= 1'b1;
			tomb_idx_q  <= idx_q;
		end
		if (cmd.advance) begin
			idx_q <= (idx_q == AW'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.set_result) begin
			rsp_q <= rsp_nx;
		end
	end

	always_comb begin
		mark_we = 1'b0;
		key_we  = 1'b0;
		off_we  = 1'b0;
		mark_a  = idx_q;
		kv_a    = idx_q;
		mark_wd = MARK_USED;
		if (cmd.clr_step) begin
			mark_we = 1'b1;
			mark_a  = clr_q;
			mark_wd = MARK_EMPTY;
		end else if (cmd.wr_match) begin
			if (mode_q == MODE_INSERT) off_we = 1'b1;
			if (mode_q == MODE_DELETE) begin
				mark_we = 1'b1;
				mark_wd = MARK_TOMB;
			end
		end else if (cmd.wr_place) begin
			mark_we = 1'b1;
			key_we  = 1'b1;
			off_we  = 1'b1;
			if (have_tomb_q) begin
				mark_a = tomb_idx_q;
				kv_a   = tomb_idx_q;
			end
		end
	end

	lphi_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_mark (
		.clk(clk), .we(mark_we), .addr(mark_a), .wdata(mark_wd), .rdata(mark_rd));
	lphi_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key (
		.clk(clk), .we(key_we), .addr(kv_a), .wdata(key_q), .rdata(key_rd));
	lphi_ram #(.WIDTH(48), .DEPTH(SLOTS)) u_off (
		.clk(clk), .we(off_we), .addr(kv_a), .wdata(off_q), .rdata(off_rd));

	assign sts.clr_last   = (clr_q == AW'(SLOTS - 1));
	assign sts.hash_done  = hdone_q;
	assign sts.home_done  = home_ok;
	assign sts.mark       = mark_rd;
	assign sts.key_eq     = (key_rd == key_q);
	assign sts.have_tomb  = have_tomb_q;
	assign sts.probe_last = (cnt_q == (AW+1)'(SLOTS - 1));
	assign sts.mode       = mode_q;
	assign rsp            = rsp_q;
endmodule

@@ hw/rtl/linear_probe_hash_index_unit.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_index_unit: key-to-offset index, open addressing
// One request at a time; one result per request.
// ----------------------------------------------------------------------------
// After reset the unit sweeps every slot mark and stalls input meanwhile. A
// request is then accepted in the idle state, hashed by FNV-1a (one byte a
// cycle through the 32-bit multiplier) and reduced to its home slot, by a mask
// when SLOTS is a power of two and by reciprocal multiply otherwise. Each
// probed slot passes the read, wait and check states for the registered read
// of the slot memories. A match goes straight to the result; otherwise the key
// is placed, a miss settled or a full table reported. The result is then
// presented and held while it is stalled.
module linear_probe_hash_index_unit #(
	parameter int SLOTS       = 1024,
	parameter int KEY_BYTES   = 8,
	parameter int OFFSET_BITS = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  lphi_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output lphi_pkg::rsp_t out_data
);
	import lphi_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lphi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd));

	lphi_dp #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES), .OFFSET_BITS(OFFSET_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .rsp(out_data), .cmd(cmd), .sts(sts));
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for linear_probe_hash_index_unit
// Random and directed lookups, inserts, deletes and spare-mode requests against a
// behavioural table with FNV-1a hashing and linear probing; results checked in order.
// ----------------------------------------------------------------------------
module tb_top;
	import lphi_pkg::*;

	localparam int SLOTS = 1024;
	localparam int LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_data;

	linear_probe_hash_index_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [1:0]  tbl_mark [SLOTS];
	logic [63:0] tbl_key [SLOTS];
	logic [47:0] tbl_off [SLOTS];

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	logic [63:0] key_pool[$];
	int n_errors = 0;
	int n_sent = 0;
	int n_total = 0;
	int hold_off = 0;
	bit held = 0;
	bit quiet = 0;
	bit in_taken = 0;
	int cycles = 0;

	function automatic logic [63:0] norm_key(logic [63:0] k);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (k[8*i +: 8] == 8'h00) break;
			r[8*i +: 8] = k[8*i +: 8];
		end
		return r;
	endfunction

	function automatic logic [31:0] fnv_hash(logic [63:0] k);
		logic [31:0] h;
		h = FNV_BASIS;
		for (int i = 0; i < 8; i++) begin
			if (k[8*i +: 8] == 8'h00) break;
			h = h ^ {24'h0, k[8*i +: 8]};
			h = h * FNV_PRIME;
		end
		return h;
	endfunction

	function automatic rsp_t index_access(req_t rq);
		rsp_t r;
		logic [63:0] nk;
		int idx, tomb, empt;
		bit have_tomb, have_empty;
		r = '0;
		r.status = ST_ABSENT;
		nk = norm_key(rq.key);
		idx = fnv_hash(nk) % SLOTS;
		have_tomb = 0; have_empty = 0; tomb = 0; empt = 0;
		for (int n = 0; n < SLOTS; n++) begin
			if (tbl_mark[idx] == MARK_EMPTY) begin
				have_empty = 1; empt = idx;
				break;
			end
			if (tbl_mark[idx] == MARK_USED && tbl_key[idx] == nk) begin
				r.hit = 1'b1;
				r.status = ST_DONE;
				if (rq.mode == MODE_INSERT) tbl_off[idx] = rq.new_offset;
				else if (rq.mode == MODE_DELETE) tbl_mark[idx] = MARK_TOMB;
				else r.found_offset = tbl_off[idx];
				break;
			end
			if (tbl_mark[idx] == MARK_TOMB && !have_tomb) begin
				have_tomb = 1; tomb = idx;
			end
			idx = (idx + 1) % SLOTS;
		end
		if (!r.hit && rq.mode == MODE_INSERT) begin
			if (have_tomb || have_empty) begin
				idx = have_tomb ? tomb : empt;
				tbl_key[idx] = nk;
				tbl_off[idx] = rq.new_offset;
				tbl_mark[idx] = MARK_USED;
				r.hit = 1'b1;
				r.status = ST_DONE;
			end else begin
				r.status = ST_FULL;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] rand_key();
		logic [63:0] k;
		int len;
		k = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < 8; i++)
					if (i >= len) k[8*i +: 8] = 8'h00;
					else if (k[8*i +: 8] == 8'h00) k[8*i +: 8] = 8'h41;
			end
			1: k[63:16] = {$urandom, 16'h0} >> $urandom_range(0, 47);
			default: ;
		endcase
		return k;
	endfunction

	task automatic push_req(logic [1:0] m, logic [63:0] k, logic [47:0] o);
		req_t rq;
		rq.mode = m; rq.key = k; rq.new_offset = o;
		pending_reqs.push_back(rq);
		key_pool.push_back(k);
	endtask

	initial begin
		logic [63:0] k;
		logic [1:0] m;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_mark[i] = MARK_EMPTY; tbl_key[i] = '0; tbl_off[i] = '0;
		end
		// directed: extremes, every mode, zero key, bytes after zero ignored
		push_req(MODE_LOOKUP, 64'h0, 48'h0);
		push_req(MODE_DELETE, 64'h0, 48'h0);
		push_req(MODE_INSERT, 64'h0, '1);
		push_req(MODE_LOOKUP, 64'hFFFF_0000_0000_0000, 48'h0);
		push_req(MODE_INSERT, '1, '1);
		push_req(MODE_LOOKUP, '1, 48'h0);
		push_req(MODE_INSERT, '1, 48'h1);
		push_req(MODE_SPARE, '1, '1);
		push_req(MODE_INSERT, 64'hDEAD_0000_0000_0061, 48'h5555_5555_5555);
		push_req(MODE_LOOKUP, 64'hBEEF_0000_0000_0061, 48'h0);
		push_req(MODE_DELETE, 64'h61, 48'h0);
		push_req(MODE_LOOKUP, 64'h61, 48'h0);
		push_req(MODE_DELETE, 64'h61, 48'h0);
		push_req(MODE_INSERT, 64'h62, 48'hAAAA_AAAA_AAAA);
		push_req(MODE_INSERT, 64'h61, 48'h1234);
		push_req(MODE_LOOKUP, 64'h61, 48'h0);
		push_req(MODE_DELETE, '1, 48'h0);
		push_req(MODE_LOOKUP, '1, 48'h0);
		for (int i = 0; i < 500; i++) begin
			if (key_pool.size() > 0 && $urandom_range(0, 99) < 60)
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			else
				k = rand_key();
			case ($urandom_range(0, 19))
				0: m = MODE_SPARE;
				1, 2, 3, 4, 5, 6, 7, 8: m = MODE_INSERT;
				9, 10, 11, 12: m = MODE_DELETE;
				default: m = MODE_LOOKUP;
			endcase
			push_req(m, k, {$urandom, $urandom});
		end
		n_total = pending_reqs.size();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk)
		in_taken <= in_valid && !in_stall;

	// sender: bursts of idle, none over the final stretch
	int tx_gap = 0;
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (in_valid) n_sent <= n_sent + 1;
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (!quiet && n_sent > 0 && $urandom_range(0, 15) == 0) begin
				tx_gap <= $urandom_range(0, 18);
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				in_data <= pending_reqs.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk)
		if (in_valid && !in_stall) expected_rsps.push_back(index_access(in_data));

	// one long hold-off of the receiver
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
		end else if (!held && n_sent >= 100) begin
			hold_off <= 300;
			held <= 1;
		end
	end

	// receiver stalls
	int rx_gap = 0;
	always @(negedge clk) begin
		quiet <= (n_sent > n_total - 60);
		if (hold_off > 0) begin
			out_stall <= 1'b1;
		end else if (rx_gap > 1) begin
			rx_gap <= rx_gap - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			rx_gap <= $urandom_range(1, 19);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rsps.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("unexpected transfer: %p", out_data);
			end else begin
				exp_r = expected_rsps.pop_front();
				if (out_data.hit !== exp_r.hit || out_data.found_offset !== exp_r.found_offset
					|| out_data.status !== exp_r.status) begin
					n_errors++;
					if (n_errors <= 10)
						$display("mismatch: exp hit %0d off %h st %0d, got hit %0d off %h st %0d",
							exp_r.hit, exp_r.found_offset, exp_r.status,
							out_data.hit, out_data.found_offset, out_data.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("** linear_probe_hash_index_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		wait (arst_n);
		wait (pending_reqs.size() == 0 && n_sent == n_total && expected_rsps.size() == 0);
		repeat (200) @(posedge clk);
		if (n_errors == 0 && expected_rsps.size() == 0)
			$display("** linear_probe_hash_index_unit: PASSED **");
		else
			$display("** linear_probe_hash_index_unit: FAILED **");
		$finish;
	end

endmodule
